>>> hdl/urxf_pkg.sv
// Shared types, codes and constants of the UART receive FIFO with idle detection.
`default_nettype none

package urxf_pkg;

    // Default ring depth in bytes
    localparam int FIFO_DEPTH_DEF = 64;

    // Fixed field widths of the streaming items
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;
    localparam int FILL_W   = 7;
    localparam int ACTION_W = 2;
    localparam int TMO_W    = 8;

    // Reset value of the idle timeout register, in ticks
    localparam logic [TMO_W-1:0] TIMEOUT_RST = 8'd2;

    // Depth of the command queue between front and back (power of two)
    localparam int CMDQ_DEPTH = 2;

    // Action codes as they arrive on the input stream
    typedef logic [ACTION_W-1:0] action_t;
    localparam action_t ACT_RX_BYTE = 2'd0;
    localparam action_t ACT_READ    = 2'd1;
    localparam action_t ACT_TICK    = 2'd2;

    // Command kinds handed from front to back
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_RX_BYTE = 2'd0;
    localparam kind_t KIND_READ    = 2'd1;
    localparam kind_t KIND_TICK    = 2'd2;
    localparam kind_t KIND_NOP     = 2'd3;

    // One classified command
    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  rx_byte;
        logic [LEN_W-1:0]   read_len;
    } cmd_t;

endpackage

`default_nettype wire

>>> hdl/urxf_front.sv
// Front end: accepts input transfers, classifies the action and hands a command on.
`default_nettype none

module urxf_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,  // rx_byte[7:0], read_len[14:8], zero
    input  wire logic [urxf_pkg::ACTION_W-1:0] s_tuser,  // action[1:0]
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output urxf_pkg::cmd_t                     cmd
);
    import urxf_pkg::*;

    logic slot_valid_reg, slot_valid_next;
    cmd_t slot_cmd_reg;
    cmd_t cls_cmd;
    logic s_take;

    // Accept whenever the slot is empty or drains this cycle
    assign s_tready  = !slot_valid_reg || cmd_ready;
    assign s_take    = s_tvalid && s_tready;
    assign cmd_valid = slot_valid_reg;
    assign cmd       = slot_cmd_reg;

    // Classify the action and keep only the fields the command uses
    always_comb begin
        cls_cmd = '0;
        unique case (action_t'(s_tuser))
            ACT_RX_BYTE: begin
                cls_cmd.kind    = KIND_RX_BYTE;
                cls_cmd.rx_byte = s_tdata[BYTE_W-1:0];
            end
            ACT_READ: begin
                cls_cmd.kind     = KIND_READ;
                cls_cmd.read_len = s_tdata[BYTE_W+LEN_W-1:BYTE_W];
            end
            ACT_TICK: begin
                cls_cmd.kind = KIND_TICK;
            end
            default: begin
                cls_cmd.kind = KIND_NOP;
            end
        endcase
    end

    // Slot occupancy
    always_comb begin
        slot_valid_next = slot_valid_reg;
        if (s_take) begin
            slot_valid_next = 1'b1;
        end else if (cmd_ready) begin
            slot_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= 1'b0;
        end else begin
            slot_valid_reg <= slot_valid_next;
        end
    end

    // Hold the classified command
    always_ff @(posedge aclk) begin
        if (s_take) begin
            slot_cmd_reg <= cls_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hdl/urxf_cmd_queue.sv
// Short command queue that decouples the front end from the back end.
`default_nettype none

module urxf_cmd_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire urxf_pkg::cmd_t in_cmd,
    output logic                out_valid,
    input  wire logic           out_ready,
    output urxf_pkg::cmd_t      out_cmd
);
    import urxf_pkg::*;

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t             entry_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(CMDQ_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers; the depth is a power of two so they wrap naturally
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hdl/urxf_back.sv
// Back end: byte ring, idle timer, timeout register and the result register.
`default_nettype none

module urxf_back #(
    parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  wire urxf_pkg::cmd_t              cmd,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [urxf_pkg::TMO_W-1:0]  cfg_data,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [15:0]                      m_tdata,
    output logic [2:0]                       m_tuser,
    output logic                             m_tlast
);
    import urxf_pkg::*;

    localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // Byte ring
    logic [BYTE_W-1:0] mem [FIFO_DEPTH];
    logic [BYTE_W-1:0] rd_q_reg;

    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic              busy_reg, busy_next;

    // Idle timer and its register
    logic [TMO_W-1:0]  countdown_reg, countdown_next;
    logic              armed_reg, armed_next;
    logic [TMO_W-1:0]  timeout_reg;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic              out_rd_reg, out_rd_next;
    logic              out_last_reg, out_last_next;
    logic              out_drop_reg, out_drop_next;
    logic              out_idle_reg, out_idle_next;
    logic [FILL_W-1:0] out_fill_reg, out_fill_next;

    logic              out_free, take, do_write, do_read, is_full;
    logic [LEN_W-1:0]  held_ext, read_n;

    function automatic logic [IDX_W-1:0] adv_idx(input logic [IDX_W-1:0] idx);
        adv_idx = (idx == IDX_W'(FIFO_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign out_free  = !out_valid_reg || m_tready;
    assign cmd_ready = out_free && !busy_reg;
    assign take      = cmd_valid && cmd_ready;
    assign is_full   = held_reg == CNT_W'(FIFO_DEPTH);
    assign held_ext  = LEN_W'(held_reg);
    assign read_n    = (cmd.read_len < held_ext) ? cmd.read_len : held_ext;
    assign cfg_ready = 1'b1;

    // Execute one command or one further byte of a running read
    always_comb begin
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        held_next      = held_reg;
        left_next      = left_reg;
        busy_next      = busy_reg;
        countdown_next = countdown_reg;
        armed_next     = armed_reg;
        out_valid_next = out_valid_reg;
        out_rd_next    = out_rd_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;
        out_idle_next  = out_idle_reg;
        out_fill_next  = out_fill_reg;
        do_write       = 1'b0;
        do_read        = 1'b0;

        if (out_free) begin
            out_valid_next = 1'b0;
        end

        if (out_free && busy_reg) begin
            // Stream the next byte of a read
            do_read        = 1'b1;
            rd_idx_next    = adv_idx(rd_idx_reg);
            held_next      = held_reg - 1'b1;
            left_next      = left_reg - 1'b1;
            busy_next      = left_reg != CNT_W'(1);
            out_valid_next = 1'b1;
            out_rd_next    = 1'b1;
            out_last_next  = left_reg == CNT_W'(1);
            out_drop_next  = 1'b0;
            out_idle_next  = 1'b0;
            out_fill_next  = FILL_W'(held_reg - 1'b1);
        end else if (take) begin
            out_valid_next = 1'b1;
            out_rd_next    = 1'b0;
            out_last_next  = 1'b1;
            out_drop_next  = 1'b0;
            out_idle_next  = 1'b0;
            out_fill_next  = FILL_W'(held_reg);
            unique case (cmd.kind)
                KIND_RX_BYTE: begin
                    // Store unless full, drop otherwise; rearm the timer either way
                    if (!is_full) begin
                        do_write      = 1'b1;
                        wr_idx_next   = adv_idx(wr_idx_reg);
                        held_next     = held_reg + 1'b1;
                        out_fill_next = FILL_W'(held_reg + 1'b1);
                    end
                    out_drop_next  = is_full;
                    countdown_next = timeout_reg;
                    armed_next     = 1'b1;
                end
                KIND_READ: begin
                    if (held_reg == '0) begin
                        // Empty: reset both indices
                        wr_idx_next = '0;
                        rd_idx_next = '0;
                    end else if (read_n != '0) begin
                        do_read       = 1'b1;
                        rd_idx_next   = adv_idx(rd_idx_reg);
                        held_next     = held_reg - 1'b1;
                        left_next     = CNT_W'(read_n - 1'b1);
                        busy_next     = read_n != LEN_W'(1);
                        out_rd_next   = 1'b1;
                        out_last_next = read_n == LEN_W'(1);
                        out_fill_next = FILL_W'(held_reg - 1'b1);
                    end
                end
                KIND_TICK: begin
                    if (armed_reg) begin
                        if (countdown_reg <= TMO_W'(1)) begin
                            countdown_next = '0;
                            armed_next     = 1'b0;
                            out_idle_next  = 1'b1;
                        end else begin
                            countdown_next = countdown_reg - 1'b1;
                        end
                    end
                end
                default: begin
                    // Unused action: report the fill level only
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            held_reg      <= '0;
            left_reg      <= '0;
            busy_reg      <= 1'b0;
            countdown_reg <= '0;
            armed_reg     <= 1'b0;
            timeout_reg   <= TIMEOUT_RST;
            out_valid_reg <= 1'b0;
        end else begin
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            held_reg      <= held_next;
            left_reg      <= left_next;
            busy_reg      <= busy_next;
            countdown_reg <= countdown_next;
            armed_reg     <= armed_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        out_rd_reg   <= out_rd_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
        out_idle_reg <= out_idle_next;
        out_fill_reg <= out_fill_next;
    end

    // Byte ring: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[wr_idx_reg] <= cmd.rx_byte;
        end
        if (do_read) begin
            rd_q_reg <= mem[rd_idx_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_fill_reg, out_rd_reg ? rd_q_reg : {BYTE_W{1'b0}}};
    assign m_tuser  = {out_idle_reg, out_drop_reg, out_rd_reg};

endmodule

`default_nettype wire

>>> hdl/uart_rx_fifo_idle_detect_core.sv
// Top level of the UART receive FIFO with idle-line detection.
//
// Each input transfer carries one action: a received byte (stored in a ring of
// FIFO_DEPTH bytes, or dropped when full, and rearming the one-shot idle timer),
// a read request (returns up to read_len bytes in order, tlast on the final one,
// or a single no-data report that on an empty ring also resets the indices) or a
// millisecond tick (counts the armed timer down and flags one idle event on
// expiry). Every action yields at least one result. A classifying front end and
// a two-entry command queue sit before the back end, so input keeps flowing
// while results wait. Unless results stall or a read streams, bytes, ticks and
// short reads are taken one per cycle and longer reads stream one byte per
// cycle, bound by the single read port of the byte ring. The first result passes
// front slot, command queue and result register. The timeout register resets
// to 2 ticks; the user must write it through the cfg channel only while the
// block is idle, unchecked by the block. A new value applies at the next rearm.
`default_nettype none

module uart_rx_fifo_idle_detect_core #(
    parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,   // rx_byte[7:0], read_len[14:8], zero
    input  wire logic [urxf_pkg::ACTION_W-1:0] s_tuser,   // action[1:0]
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [urxf_pkg::TMO_W-1:0]    cfg_data,  // idle_timeout_ms
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,   // data_byte[7:0], fill_count[14:8], zero
    output logic [2:0]                         m_tuser,   // data_valid, dropped, idle_event
    output logic                               m_tlast    // last
);
    import urxf_pkg::*;

    logic front_valid, front_ready;
    cmd_t front_cmd;
    logic q_valid, q_ready;
    cmd_t q_cmd;

    urxf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    urxf_cmd_queue u_cmd_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    urxf_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

>>> hdl/urxf_checker.sv
// Port-level checks on the result stream, bound to the top level.
`default_nettype none

module urxf_checker #(
    parameter int FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEF
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // Results without FIFO data are always the only result of their action
    a_nodata_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[7:0] == 8'd0))
        else $error("non-data result not marked last or carries data");

    // Fill level never exceeds the ring depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[14:8] <= 7'(FIFO_DEPTH))
        else $error("fill level beyond ring depth");

    // Inside a read burst the next byte follows at once with one byte less held
    a_burst_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser[0] && !m_tlast |=>
            m_tvalid && m_tuser[0] && (m_tdata[14:8] == $past(m_tdata[14:8]) - 7'd1))
        else $error("read burst broken or fill level not decremented");

endmodule

bind uart_rx_fifo_idle_detect_core urxf_checker #(
    .FIFO_DEPTH (FIFO_DEPTH)
) u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> verif/urxf_fifo_checker.sv
// Checker for the UART receive FIFO: predicts each result from accepted transfers and compares.
module urxf_fifo_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [15:0]                   s_tdata,   // rx_byte[7:0], read_len[14:8], zero
    input  wire logic [urxf_pkg::ACTION_W-1:0] s_tuser,   // action[1:0]
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [urxf_pkg::TMO_W-1:0]    cfg_data,  // idle_timeout_ms
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [15:0]                   m_tdata,   // data_byte[7:0], fill_count[14:8], zero
    input  wire logic [2:0]                    m_tuser,   // data_valid, dropped, idle_event
    input  wire logic                          m_tlast,
    output int                                 fail_count,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import urxf_pkg::*;

    localparam int DEPTH     = FIFO_DEPTH_DEF;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              data_valid;
        logic              last;
        logic              dropped;
        logic              idle_event;
        logic [FILL_W-1:0] fill;
    } fifo_result_t;

    // Own copy of the ring, its indices, the idle timer and the timeout register
    logic [BYTE_W-1:0] ring [DEPTH];
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  rd_ptr;
    logic [FILL_W-1:0] held;
    logic [TMO_W-1:0]  countdown;
    logic [TMO_W-1:0]  timeout;
    logic              armed;

    fifo_result_t due_results[$];

    function automatic logic [PTR_W-1:0] ring_step(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    task automatic queue_result(input logic [BYTE_W-1:0] b, input logic v, input logic l,
                                input logic d, input logic i);
        fifo_result_t r;
        r.data_byte  = b;
        r.data_valid = v;
        r.last       = l;
        r.dropped    = d;
        r.idle_event = i;
        r.fill       = held;
        due_results.push_back(r);
    endtask

    // Work out every result that one accepted action causes
    task automatic apply_uart_action(input action_t act, input logic [BYTE_W-1:0] rx,
                                     input logic [LEN_W-1:0] len);
        int  n;
        logic drop;
        logic fired;
        case (act)
            ACT_RX_BYTE: begin
                drop = (held >= FILL_W'(DEPTH));
                if (!drop) begin
                    ring[wr_ptr] = rx;
                    wr_ptr       = ring_step(wr_ptr);
                    held         = held + 1'b1;
                end
                countdown = timeout;
                armed     = 1'b1;
                queue_result('0, 1'b0, 1'b1, drop, 1'b0);
            end
            ACT_READ: begin
                if (held == '0) begin
                    // Empty read: report nothing held and rewind both indices
                    rd_ptr = '0;
                    wr_ptr = '0;
                    queue_result('0, 1'b0, 1'b1, 1'b0, 1'b0);
                end else begin
                    n = (int'(len) < int'(held)) ? int'(len) : int'(held);
                    if (n == 0) begin
                        queue_result('0, 1'b0, 1'b1, 1'b0, 1'b0);
                    end else begin
                        for (int k = 0; k < n; k++) begin
                            held = held - 1'b1;
                            queue_result(ring[rd_ptr], 1'b1, k == n - 1, 1'b0, 1'b0);
                            rd_ptr = ring_step(rd_ptr);
                        end
                    end
                end
            end
            ACT_TICK: begin
                fired = 1'b0;
                if (armed) begin
                    // A countdown of one or less (zero timeout included) expires now
                    if (countdown <= 1) begin
                        countdown = '0;
                        armed     = 1'b0;
                        fired     = 1'b1;
                    end else begin
                        countdown = countdown - 1'b1;
                    end
                end
                queue_result('0, 1'b0, 1'b1, 1'b0, fired);
            end
            default: begin
                queue_result('0, 1'b0, 1'b1, 1'b0, 1'b0);
            end
        endcase
    endtask

    // Compare one transfer on the result channel with the oldest expectation
    task automatic check_result();
        fifo_result_t got;
        fifo_result_t want;
        got.data_byte  = m_tdata[7:0];
        got.fill       = m_tdata[14:8];
        got.data_valid = m_tuser[0];
        got.dropped    = m_tuser[1];
        got.idle_event = m_tuser[2];
        got.last       = m_tlast;
        if (due_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
                $display({"%0t: result with nothing due: byte %02h valid %0b last %0b",
                          " drop %0b idle %0b fill %0d"},
                         $realtime, got.data_byte, got.data_valid, got.last, got.dropped,
                         got.idle_event, got.fill);
        end else begin
            want = due_results.pop_front();
            if (got !== want) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN) begin
                    $display({"%0t: mismatch, expected byte %02h valid %0b last %0b",
                              " drop %0b idle %0b fill %0d"},
                             $realtime, want.data_byte, want.data_valid, want.last,
                             want.dropped, want.idle_event, want.fill);
                    $display({"%0t:           actual   byte %02h valid %0b last %0b",
                              " drop %0b idle %0b fill %0d"},
                             $realtime, got.data_byte, got.data_valid, got.last,
                             got.dropped, got.idle_event, got.fill);
                end
            end
        end
    endtask

    // Check outputs before predicting, so no result can match its own input in the same cycle
    always @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr     = '0;
            rd_ptr     = '0;
            held       = '0;
            countdown  = '0;
            armed      = 1'b0;
            timeout    = TIMEOUT_RST;
            fail_count = 0;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (cfg_valid && cfg_ready)
                timeout = cfg_data;
            if (s_tvalid && s_tready)
                apply_uart_action(s_tuser, s_tdata[7:0], s_tdata[14:8]);
        end
        pending = due_results.size();
    end

endmodule

>>> verif/uart_rx_fifo_idle_detect_core_tb.sv
// Testbench top for the UART receive FIFO with idle detection: stimulus, idling and verdict.
module uart_rx_fifo_idle_detect_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import urxf_pkg::*;

    // Action code the block does not define; it must still give one plain result
    localparam action_t ACT_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PRESSURE_AT     = 70;
    localparam int DRAIN_CYCLES    = 10;
    localparam int PHASE_ITEMS     = 13;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [15:0]        s_tdata;   // rx_byte[7:0], read_len[14:8], zero
    logic [ACTION_W-1:0] s_tuser;  // action[1:0]
    logic               cfg_valid;
    logic               cfg_ready;
    logic [TMO_W-1:0]   cfg_data;  // idle_timeout_ms
    logic               m_tvalid;
    logic               m_tready;
    logic [15:0]        m_tdata;   // data_byte[7:0], fill_count[14:8], zero
    logic [2:0]         m_tuser;   // data_valid, dropped, idle_event
    logic               m_tlast;

    int fail_count;
    int pending;
    int items_sent;
    int timeout_now;
    int stall_cycles;
    bit quiet;
    bit pressure_done;

    uart_rx_fifo_idle_detect_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    urxf_fifo_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Abort when no channel completes a transfer for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result side: random stalls, one long hold-off while the sender keeps offering
    initial begin
        m_tready      = 1'b0;
        pressure_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!pressure_done && items_sent >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            m_tready <= quiet || ($urandom_range(99) >= 6);
        end
    end

    // Offer one action and hold it until the transfer completes
    task automatic send_item(input action_t act, input logic [7:0] rx, input logic [6:0] len);
        while (!quiet && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tuser  <= act;
        s_tdata  <= {1'b0, len, rx};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    // Write the timeout once every due result has come back
    task automatic write_timeout(input logic [TMO_W-1:0] value);
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid   <= 1'b0;
        timeout_now = value;
    endtask

    task automatic byte_burst(input int count);
        repeat (count) send_item(ACT_RX_BYTE, 8'($urandom_range(255)), 7'($urandom_range(127)));
    endtask

    // Random traffic: byte bursts, reads of length 0 to 16 and 64 to 127, tick runs and stray codes
    task automatic run_phase(input int target);
        int start;
        int pick;
        int n;
        int tick_cap;
        start = items_sent;
        while (items_sent - start < target) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(75, 60) : $urandom_range(12, 1);
                // Keep the phase close to its item budget
                if (n > target - (items_sent - start))
                    n = target - (items_sent - start);
                byte_burst(n);
            end else if (pick < 65) begin
                pick = $urandom_range(9);
                if (pick < 7)
                    n = $urandom_range(16, 1);
                else if (pick == 7)
                    n = 0;
                else if (pick == 8)
                    n = 64;
                else
                    n = $urandom_range(127, 65);
                send_item(ACT_READ, 8'($urandom_range(255)), 7'(n));
            end else if (pick < 90) begin
                tick_cap = (timeout_now > 6) ? 6 : timeout_now;
                n = $urandom_range(tick_cap + 2, 1);
                repeat (n) send_item(ACT_TICK, 8'($urandom_range(255)), 7'($urandom_range(127)));
            end else begin
                send_item(ACT_UNUSED, 8'($urandom_range(255)), 7'($urandom_range(127)));
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ACT_RX_BYTE;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        quiet       = 1'b0;
        items_sent  = 0;
        timeout_now = TIMEOUT_RST;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // Empty read, tick on a stopped timer and the undefined action code
        send_item(ACT_READ, 8'h00, 7'd5);
        send_item(ACT_TICK, 8'h00, 7'd0);
        send_item(ACT_UNUSED, 8'hFF, 7'h7F);
        // Byte extremes, a zero-length read with data held, a short read
        send_item(ACT_RX_BYTE, 8'h00, 7'd0);
        send_item(ACT_RX_BYTE, 8'hFF, 7'h7F);
        send_item(ACT_RX_BYTE, 8'hA5, 7'd0);
        send_item(ACT_RX_BYTE, 8'h5A, 7'd0);
        send_item(ACT_READ, 8'h00, 7'd0);
        send_item(ACT_READ, 8'hFF, 7'd2);
        // Count down to expiry, then one tick past it
        repeat (3) send_item(ACT_TICK, 8'h00, 7'd0);
        send_item(ACT_RX_BYTE, 8'h3C, 7'd0);
        // Change the timeout while armed: the running countdown is kept
        write_timeout(8'd0);
        repeat (2) send_item(ACT_TICK, 8'h00, 7'd0);
        // Zero timeout fires on the very next tick
        send_item(ACT_RX_BYTE, 8'h81, 7'd0);
        send_item(ACT_TICK, 8'h00, 7'd0);
        // Read beyond the held count, then read an empty ring
        send_item(ACT_READ, 8'h00, 7'h7F);
        send_item(ACT_READ, 8'h00, 7'd64);

        // Fill past the top so bytes are dropped, then random traffic
        write_timeout(8'd1);
        byte_burst(66);
        run_phase(PHASE_ITEMS);
        write_timeout(8'd255);
        quiet = 1'b1;
        run_phase(PHASE_ITEMS);
        quiet = 1'b0;
        write_timeout(8'(3 + $urandom_range(5)));
        run_phase(PHASE_ITEMS);
        write_timeout(8'd2);
        run_phase(PHASE_ITEMS);
        write_timeout(8'(2 + $urandom_range(253)));
        run_phase(PHASE_ITEMS);

        // Drain and let the pipeline settle
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
hdl/urxf_pkg.sv
hdl/urxf_front.sv
hdl/urxf_cmd_queue.sv
hdl/urxf_back.sv
hdl/uart_rx_fifo_idle_detect_core.sv
hdl/urxf_checker.sv
verif/urxf_fifo_checker.sv
verif/uart_rx_fifo_idle_detect_core_tb.sv
